// ----- hdl/tcc_pkg.sv -----
`default_nettype none

package tcc_pkg;

   localparam int COLS_DEFAULT = 80;
   localparam int ROWS_DEFAULT = 20;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_RETURN  = 8'h0D;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_WRITE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL,
      ST_DRAIN,
      ST_FILL
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/tcc_ram.sv -----
`default_nettype none

module tcc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1600
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hdl/text_console_cursor_scroll_unit.sv -----
`default_nettype none

// Text console with a COLS x ROWS grid of 16-bit cells (attribute byte over
// character byte) held in one single-port-write RAM, plus a cursor. An item is
// taken when start is high and busy is low; its result appears on the rsp_
// ports for exactly one cycle with rsp_strobe and cannot be held off. An
// in-grid read waits in an extra state for the RAM read data. Clear screen
// walks the RAM one cell a cycle; a newline on the bottom row scrolls by
// copying one cell a cycle through the RAM read port and then blanking the
// last row. After reset the same sweep clears the RAM, so busy stays high
// until that sweep is done and no item is taken before then.
module text_console_cursor_scroll_unit #(
   parameter int COLS = tcc_pkg::COLS_DEFAULT,
   parameter int ROWS = tcc_pkg::ROWS_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire tcc_pkg::op_type req_op,
   input  wire logic [7:0]      req_ch,
   input  wire logic [6:0]      req_col,
   input  wire logic [4:0]      req_row,
   input  wire logic [3:0]      req_fg,
   input  wire logic [3:0]      req_bg,
   output logic                 rsp_strobe,
   output logic [15:0]          rsp_read_data,
   output logic [6:0]           rsp_cursor_col,
   output logic [4:0]           rsp_cursor_row,
   output logic                 rsp_bad_position
);

   import tcc_pkg::*;

   localparam int CELL_COUNT = COLS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int POS_W      = 12;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [7:0]         ch_ff, ch_in;
   logic [7:0]         attr_ff, attr_in;
   logic               inside_ff, inside_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic               silent_ff, silent_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [6:0]         cur_col_ff, cur_col_in;
   logic [4:0]         cur_row_ff, cur_row_in;
   logic [ADDR_W-1:0]  cur_lin_ff, cur_lin_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [15:0]        wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [15:0]        rd_data;
   logic [POS_W-1:0]   req_pos;
   logic               accept;

   assign accept  = start && !busy;
   assign req_pos = POS_W'(req_row) * POS_W'(COLS) + POS_W'(req_col);
   assign rd_addr = (state_ff == ST_SCROLL) ? sweep_ff + ADDR_W'(COLS) : addr_ff;

   tcc_ram #(
      .WIDTH (16),
      .DEPTH (CELL_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         sweep_ff      <= '0;
         silent_ff     <= 1'b1;
         pend_ff       <= 1'b0;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         cur_lin_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         silent_ff     <= silent_in;
         pend_ff       <= pend_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         cur_lin_ff    <= cur_lin_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      attr_ff      <= attr_in;
      inside_ff    <= inside_in;
      addr_ff      <= addr_in;
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ch_in         = ch_ff;
      attr_in       = attr_ff;
      inside_in     = inside_ff;
      addr_in       = addr_ff;
      sweep_in      = sweep_ff;
      silent_in     = silent_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      cur_lin_in    = cur_lin_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_bad_in    = rsp_bad_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = {attr_ff, ch_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               ch_in     = req_ch;
               attr_in   = {req_bg, req_fg};
               inside_in = ({1'b0, req_col} < 8'(COLS)) && ({1'b0, req_row} < 6'(ROWS));
               addr_in   = (req_op == OP_PUT) ? cur_lin_ff : ADDR_W'(req_pos);
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_data_in = '0;
            rsp_bad_in  = 1'b0;
            case (op_ff)
               OP_PUT: begin
                  if (ch_ff == CHAR_NEWLINE) begin
                     cur_col_in = '0;
                     cur_lin_in = cur_lin_ff - ADDR_W'(cur_col_ff);
                     if (cur_row_ff == 5'(ROWS - 1)) begin
                        sweep_in = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        cur_row_in    = cur_row_ff + 5'd1;
                        cur_lin_in    = cur_lin_ff - ADDR_W'(cur_col_ff) + ADDR_W'(COLS);
                        rsp_strobe_in = 1'b1;
                        state_in      = ST_IDLE;
                     end
                  end else if (ch_ff == CHAR_RETURN) begin
                     cur_col_in    = '0;
                     cur_lin_in    = cur_lin_ff - ADDR_W'(cur_col_ff);
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = {8'h00, ch_ff};
                     if (cur_col_ff != 7'(COLS - 1)) begin
                        cur_col_in = cur_col_ff + 7'd1;
                        cur_lin_in = cur_lin_ff + ADDR_W'(1);
                     end
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               OP_WRITE: begin
                  wr_en         = inside_ff;
                  rsp_bad_in    = !inside_ff;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
               OP_CLEAR: begin
                  sweep_in  = '0;
                  silent_in = 1'b0;
                  state_in  = ST_FILL;
               end
               OP_READ: begin
                  if (inside_ff) begin
                     state_in = ST_READ;
                  end else begin
                     rsp_bad_in    = 1'b1;
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_READ: begin
            rsp_data_in   = rd_data;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCROLL: begin
            wr_en        = pend_ff;
            wr_addr      = pend_addr_ff;
            wr_data      = rd_data;
            pend_in      = 1'b1;
            pend_addr_in = sweep_ff;
            if (sweep_ff == ADDR_W'(CELL_COUNT - COLS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            wr_en     = pend_ff;
            wr_addr   = pend_addr_ff;
            wr_data   = rd_data;
            sweep_in  = ADDR_W'(CELL_COUNT - COLS);
            silent_in = 1'b0;
            state_in  = ST_FILL;
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = '0;
            if (sweep_ff == ADDR_W'(CELL_COUNT - 1)) begin
               rsp_strobe_in = !silent_ff;
               rsp_data_in   = '0;
               rsp_bad_in    = 1'b0;
               silent_in     = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_cursor_col   = cur_col_ff;
   assign rsp_cursor_row   = cur_row_ff;
   assign rsp_bad_position = rsp_bad_ff;

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without preceding work");

   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cur_col_ff} < 8'(COLS)) && ({1'b0, cur_row_ff} < 6'(ROWS)))
      else $error("cursor left the grid");

   a_cursor_linear: assert property (@(posedge clock) disable iff (reset)
      POS_W'(cur_lin_ff) == POS_W'(cur_row_ff) * POS_W'(COLS) + POS_W'(cur_col_ff))
      else $error("linear cursor out of step with column and row");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted item not executed");

   a_pend_in_scroll: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SCROLL || state_ff == ST_DRAIN))
      else $error("scroll copy pending outside scroll");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;
   import tcc_pkg::*;

   localparam int COLS = COLS_DEFAULT;
   localparam int ROWS = ROWS_DEFAULT;
   localparam int CELL_COUNT = COLS * ROWS;
   localparam int RANDOM_CMDS = 2000;

   typedef struct {
      op_type     op;
      logic [7:0] ch;
      logic [6:0] col;
      logic [4:0] row;
      logic [3:0] fg;
      logic [3:0] bg;
      int         idle_pct;
      bit         drain_first;
   } console_cmd_type;

   typedef struct {
      logic [15:0] read_data;
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic        bad_position;
   } console_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   op_type      req_op = OP_PUT;
   logic [7:0]  req_ch = '0;
   logic [6:0]  req_col = '0;
   logic [4:0]  req_row = '0;
   logic [3:0]  req_fg = '0;
   logic [3:0]  req_bg = '0;
   logic        rsp_strobe;
   logic [15:0] rsp_read_data;
   logic [6:0]  rsp_cursor_col;
   logic [4:0]  rsp_cursor_row;
   logic        rsp_bad_position;

   console_cmd_type   pending_cmds[$];
   console_reply_type expected_replies[$];
   console_cmd_type   cmd_on_bus;

   logic [15:0] screen_model [0:CELL_COUNT-1] = '{default: '0};
   int unsigned model_col = 0;
   int unsigned model_row = 0;

   int error_count = 0;
   int cycle_count = 0;
   int cycle_limit = 0;
   int sender_idle_pct = 0;
   bit drain_next = 1'b0;

   text_console_cursor_scroll_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_ch           (req_ch),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_fg           (req_fg),
      .req_bg           (req_bg),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_data    (rsp_read_data),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_bad_position (rsp_bad_position)
   );

   always #5 clock = ~clock;

   function automatic console_reply_type predict_console(input console_cmd_type c);
      console_reply_type r;
      bit                in_grid;
      in_grid = (c.col < COLS) && (c.row < ROWS);
      r.read_data = '0;
      r.bad_position = 1'b0;
      case (c.op)
         OP_PUT: begin
            if (c.ch == CHAR_NEWLINE) begin
               model_col = 0;
               if (model_row + 1 >= ROWS) begin
                  for (int i = 0; i < CELL_COUNT - COLS; i++)
                     screen_model[i] = screen_model[i + COLS];
                  for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++)
                     screen_model[i] = '0;
               end else begin
                  model_row++;
               end
            end else if (c.ch == CHAR_RETURN) begin
               model_col = 0;
            end else begin
               screen_model[model_row * COLS + model_col] = {8'h00, c.ch};
               if (model_col < COLS - 1)
                  model_col++;
            end
         end
         OP_WRITE: begin
            if (in_grid)
               screen_model[c.row * COLS + c.col] = {c.bg, c.fg, c.ch};
            else
               r.bad_position = 1'b1;
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELL_COUNT; i++)
               screen_model[i] = '0;
         end
         default: begin
            if (in_grid)
               r.read_data = screen_model[c.row * COLS + c.col];
            else
               r.bad_position = 1'b1;
         end
      endcase
      r.cursor_col = model_col[6:0];
      r.cursor_row = model_row[4:0];
      return r;
   endfunction

   task automatic queue_cmd(input op_type op, input logic [7:0] ch, input logic [6:0] col,
                            input logic [4:0] row, input logic [3:0] fg,
                            input logic [3:0] bg);
      console_cmd_type c;
      c.op = op;
      c.ch = ch;
      c.col = col;
      c.row = row;
      c.fg = fg;
      c.bg = bg;
      c.idle_pct = sender_idle_pct;
      c.drain_first = drain_next;
      drain_next = 1'b0;
      pending_cmds.push_back(c);
      // worst case: every newline scrolls
      cycle_limit += 67;
      if (op == OP_CLEAR || (op == OP_PUT && ch == CHAR_NEWLINE))
         cycle_limit += CELL_COUNT + 3;
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            expected_replies.push_back(predict_console(cmd_on_bus));
         if (!start || !busy) begin
            if (pending_cmds.size() != 0
                && !(pending_cmds[0].drain_first && expected_replies.size() != 0)
                && $urandom_range(99) >= pending_cmds[0].idle_pct) begin
               cmd_on_bus = pending_cmds.pop_front();
               req_op <= cmd_on_bus.op;
               req_ch <= cmd_on_bus.ch;
               req_col <= cmd_on_bus.col;
               req_row <= cmd_on_bus.row;
               req_fg <= cmd_on_bus.fg;
               req_bg <= cmd_on_bus.bg;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      console_reply_type want;
      if (!reset && rsp_strobe) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected result", rsp_read_data, 16'h0);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", rsp_read_data, want.read_data);
            if (rsp_cursor_col !== want.cursor_col)
               report_mismatch("cursor_col", 16'(rsp_cursor_col), 16'(want.cursor_col));
            if (rsp_cursor_row !== want.cursor_row)
               report_mismatch("cursor_row", 16'(rsp_cursor_row), 16'(want.cursor_row));
            if (rsp_bad_position !== want.bad_position)
               report_mismatch("bad_position", 16'(rsp_bad_position),
                               16'(want.bad_position));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int          idle_by_phase [3];
      int          target;
      int          pick;
      int          n;
      int          spot;
      logic [6:0]  c;
      logic [4:0]  r;
      logic [11:0] written_spots[$];

      idle_by_phase = '{0, 71, 28};

      // directed: corners, out-of-grid, control characters, clear
      drain_next = 1'b1;
      queue_cmd(OP_WRITE, 8'h00, 7'd0, 5'd0, 4'h0, 4'h0);
      queue_cmd(OP_WRITE, 8'hFF, 7'(COLS - 1), 5'(ROWS - 1), 4'hF, 4'hF);
      queue_cmd(OP_WRITE, 8'h5A, 7'(COLS - 1), 5'd0, 4'hA, 4'h5);
      queue_cmd(OP_READ, 8'($urandom), 7'd0, 5'd0, 4'($urandom), 4'($urandom));
      queue_cmd(OP_READ, 8'($urandom), 7'(COLS - 1), 5'(ROWS - 1), 4'($urandom),
                4'($urandom));
      queue_cmd(OP_READ, 8'($urandom), 7'(COLS - 1), 5'd0, 4'($urandom), 4'($urandom));
      queue_cmd(OP_WRITE, 8'hA5, 7'(COLS), 5'd0, 4'h3, 4'hC);
      queue_cmd(OP_WRITE, 8'hFF, 7'd127, 5'd31, 4'hF, 4'hF);
      queue_cmd(OP_WRITE, 8'h11, 7'd0, 5'(ROWS), 4'h1, 4'h2);
      queue_cmd(OP_READ, 8'($urandom), 7'(COLS), 5'(ROWS - 1), 4'($urandom),
                4'($urandom));
      queue_cmd(OP_READ, 8'($urandom), 7'd0, 5'd31, 4'($urandom), 4'($urandom));
      queue_cmd(OP_READ, 8'($urandom), 7'd127, 5'd31, 4'($urandom), 4'($urandom));
      queue_cmd(OP_PUT, 8'h41, 7'($urandom), 5'($urandom), 4'($urandom), 4'($urandom));
      queue_cmd(OP_PUT, 8'h00, 7'($urandom), 5'($urandom), 4'($urandom), 4'($urandom));
      queue_cmd(OP_PUT, 8'hFF, 7'($urandom), 5'($urandom), 4'($urandom), 4'($urandom));
      queue_cmd(OP_PUT, CHAR_RETURN, 7'($urandom), 5'($urandom), 4'($urandom),
                4'($urandom));
      queue_cmd(OP_PUT, 8'h7F, 7'($urandom), 5'($urandom), 4'($urandom), 4'($urandom));
      queue_cmd(OP_PUT, CHAR_NEWLINE, 7'($urandom), 5'($urandom), 4'($urandom),
                4'($urandom));
      queue_cmd(OP_READ, 8'($urandom), 7'd0, 5'd0, 4'($urandom), 4'($urandom));
      queue_cmd(OP_READ, 8'($urandom), 7'd1, 5'd0, 4'($urandom), 4'($urandom));
      queue_cmd(OP_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom), 4'($urandom),
                4'($urandom));
      queue_cmd(OP_READ, 8'($urandom), 7'(COLS - 1), 5'(ROWS - 1), 4'($urandom),
                4'($urandom));
      queue_cmd(OP_READ, 8'($urandom), 7'd0, 5'd0, 4'($urandom), 4'($urandom));

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = idle_by_phase[phase];
         drain_next = 1'b1;
         target = pending_cmds.size() + RANDOM_CMDS / 3;
         while (pending_cmds.size() < target) begin
            if ($urandom_range(99) == 0)
               drain_next = 1'b1;
            pick = $urandom_range(99);
            if (pick < 35) begin
               // a line of text
               n = ($urandom_range(19) == 0) ? $urandom_range(COLS + 4, COLS - 4)
                                             : $urandom_range(12);
               repeat (n)
                  queue_cmd(OP_PUT, 8'($urandom_range(8'h7E, 8'h20)), 7'($urandom),
                            5'($urandom), 4'($urandom), 4'($urandom));
               queue_cmd(OP_PUT, ($urandom_range(4) == 0) ? CHAR_RETURN : CHAR_NEWLINE,
                         7'($urandom), 5'($urandom), 4'($urandom), 4'($urandom));
            end else if (pick < 55) begin
               repeat ($urandom_range(4, 1)) begin
                  c = 7'($urandom_range(COLS - 1));
                  r = 5'($urandom_range(ROWS - 1));
                  if ($urandom_range(9) == 0) begin
                     if ($urandom_range(1) == 0)
                        c = 7'($urandom_range(127, COLS));
                     else
                        r = 5'($urandom_range(31, ROWS));
                  end else begin
                     written_spots.push_back({c, r});
                     if (written_spots.size() > 16)
                        void'(written_spots.pop_front());
                  end
                  queue_cmd(OP_WRITE, 8'($urandom), c, r, 4'($urandom), 4'($urandom));
               end
            end else if (pick < 85) begin
               repeat ($urandom_range(4, 1)) begin
                  spot = $urandom_range(9);
                  if (spot < 5 && written_spots.size() != 0) begin
                     {c, r} = written_spots[$urandom_range(written_spots.size() - 1)];
                  end else if (spot < 9) begin
                     c = 7'($urandom_range(COLS - 1));
                     r = 5'($urandom_range(ROWS - 1));
                  end else begin
                     c = 7'($urandom_range(127));
                     r = 5'($urandom_range(31));
                  end
                  queue_cmd(OP_READ, 8'($urandom), c, r, 4'($urandom), 4'($urandom));
               end
            end else if (pick < 88) begin
               queue_cmd(OP_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom),
                         4'($urandom), 4'($urandom));
            end else begin
               queue_cmd(op_type'($urandom_range(3)), 8'($urandom), 7'($urandom),
                         5'($urandom), 4'($urandom), 4'($urandom));
            end
         end
      end

      cycle_limit = 4 * (cycle_limit + 2 * CELL_COUNT + 100);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || start || expected_replies.size() != 0)
         @(posedge clock);
      repeat (CELL_COUNT + 16) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
